// ===== hdl/tlni_pkg.sv =====
// tlni_pkg: shared types, codes and offset tables for the torus lattice neighbor index unit
// no dependencies; imported by every module under hdl
package tlni_pkg;

	localparam int MAX_SIDE_DEF    = 256;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int SITE_W          = 16;
	localparam int SIDE_W          = 9;
	localparam int ADDR_W          = 3;
	localparam int DATA_W          = 32;
	localparam int RST_SIDE        = 16;
	localparam int NB_MAX          = 8;

	// register index, taken from paddr[2]
	localparam logic [0:0] REG_SIDE_LENGTH = 1'b0;

	localparam logic FUNC_NEIGHBOR = 1'b0;
	localparam logic FUNC_TEST     = 1'b1;

	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_BAD_NEIGHBOR = 2'd1;
	localparam logic [1:0] ST_BAD_SITE     = 2'd2;

	localparam logic [1:0] SHELL_SQRT5 = 2'd3;

	// offsets biased by +2
	localparam logic [2:0] SHELL_DX [0:3][0:7] = '{
		'{3'd3, 3'd2, 3'd1, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd3, 3'd1, 3'd1, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd4, 3'd2, 3'd0, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd4, 3'd3, 3'd1, 3'd0, 3'd0, 3'd1, 3'd3, 3'd4}
	};
	localparam logic [2:0] SHELL_DY [0:3][0:7] = '{
		'{3'd2, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd3, 3'd3, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd2, 3'd4, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd3, 3'd4, 3'd4, 3'd3, 3'd1, 3'd0, 3'd0, 3'd1}
	};

	typedef struct packed {
		logic              func;
		logic [1:0]        shell;
		logic [2:0]        neighbor_number;
		logic [SITE_W-1:0] site;
		logic [SITE_W-1:0] other_site;
	} req_t;

	typedef struct packed {
		logic [SITE_W-1:0] neighbor_site;
		logic              is_adjacent;
		logic [1:0]        status;
	} rsp_t;

	typedef struct packed {
		logic       func;
		logic [1:0] shell;
		logic [2:0] neighbor_number;
		logic [1:0] status;
	} ctl_t;

	typedef struct packed {
		ctl_t              ctl;
		logic [SITE_W-1:0] site;
		logic [SITE_W-1:0] other_site;
	} entry_t;

	function automatic int clamp_side(int side, int max_side);
		int r;
		r = side;
		if (side < 2) begin
			r = 2;
		end else if (side > max_side) begin
			r = max_side;
		end
		return r;
	endfunction

endpackage

// ===== hdl/tlni_front.sv =====
// tlni_front: configuration register port and request classification
// depends on tlni_pkg; feeds tlni_fifo and hands the effective side to tlni_back
module tlni_front #(
	parameter int MAX_SIDE = tlni_pkg::MAX_SIDE_DEF,
	localparam int NW = $clog2(MAX_SIDE + 1),
	localparam int TW = 2 * NW
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tlni_pkg::ADDR_W-1:0] paddr,
	input  logic [tlni_pkg::DATA_W-1:0] pwdata,
	output logic [tlni_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  tlni_pkg::req_t              req,
	output logic                        push_valid,
	input  logic                        push_ready,
	output tlni_pkg::entry_t            push_entry,
	output logic [NW-1:0]               n_eff,
	output logic [TW-1:0]               total
);
	import tlni_pkg::*;

	localparam int RST_N_INT = clamp_side(RST_SIDE, MAX_SIDE);
	localparam logic [NW-1:0] RST_N = NW'(RST_N_INT);
	localparam logic [TW-1:0] RST_TOTAL = TW'(RST_N_INT * RST_N_INT);

	logic [SIDE_W-1:0] side_q;
	logic [NW-1:0]     n_q;
	logic [TW-1:0]     total_q;
	logic              wr_side;
	logic [SIDE_W-1:0] wside;
	logic [NW-1:0]     n_new;
	logic [TW-1:0]     total_new;
	logic              bad_site;
	logic              bad_nb;

	assign pready  = 1'b1;
	assign wr_side = psel && penable && pwrite && pready && (paddr[2:2] == REG_SIDE_LENGTH);
	assign wside   = pwdata[SIDE_W-1:0];
	assign n_new   = NW'(clamp_side(int'(wside), MAX_SIDE));
	// square of the clamped side kept next to it, so the range check is a plain compare
	assign total_new = {{NW{1'b0}}, n_new} * {{NW{1'b0}}, n_new};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q  <= SIDE_W'(RST_SIDE);
			n_q     <= RST_N;
			total_q <= RST_TOTAL;
		end else if (wr_side) begin
			side_q  <= wside;
			n_q     <= n_new;
			total_q <= total_new;
		end
	end

	assign prdata = (paddr[2:2] == REG_SIDE_LENGTH) ? DATA_W'(side_q) : '0;
	assign n_eff  = n_q;
	assign total  = total_q;

	always_comb begin
		bad_site = (32'(req.site) >= 32'(total_q))
			|| (req.func == FUNC_TEST && 32'(req.other_site) >= 32'(total_q));
		bad_nb = (req.func == FUNC_NEIGHBOR) && (req.shell != SHELL_SQRT5)
			&& req.neighbor_number[2];
		push_entry.ctl.func            = req.func;
		push_entry.ctl.shell           = req.shell;
		push_entry.ctl.neighbor_number = req.neighbor_number;
		push_entry.site                = req.site;
		push_entry.other_site          = req.other_site;
		if (bad_site) begin
			push_entry.ctl.status = ST_BAD_SITE;
		end else if (bad_nb) begin
			push_entry.ctl.status = ST_BAD_NEIGHBOR;
		end else begin
			push_entry.ctl.status = ST_OK;
		end
	end

	assign push_valid = req_valid;
	assign req_ready  = push_ready;

endmodule

// ===== hdl/tlni_fifo.sv =====
// tlni_fifo: short queue of classified items between front and back
// depends on tlni_pkg
module tlni_fifo #(
	parameter int DEPTH = tlni_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  tlni_pkg::entry_t push_entry,
	output logic             pop_valid,
	input  logic             pop_ready,
	output tlni_pkg::entry_t pop_entry
);
	import tlni_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t         mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== hdl/tlni_div.sv =====
// tlni_div: pipelined restoring divider, one quotient bit per stage, two dividends side by side
// depends on tlni_pkg; quotient and remainder are exact when dividend < divisor squared
module tlni_div #(
	parameter int MAX_SIDE = tlni_pkg::MAX_SIDE_DEF,
	localparam int NW = $clog2(MAX_SIDE + 1),
	localparam int QW = $clog2(MAX_SIDE)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  tlni_pkg::ctl_t              in_ctl,
	input  logic [tlni_pkg::SITE_W-1:0] dividend_a,
	input  logic [tlni_pkg::SITE_W-1:0] dividend_b,
	input  logic [NW-1:0]               divisor,
	output logic                        out_valid,
	output tlni_pkg::ctl_t              out_ctl,
	output logic [QW-1:0]               quo_a,
	output logic [QW-1:0]               rem_a,
	output logic [QW-1:0]               quo_b,
	output logic [QW-1:0]               rem_b
);
	import tlni_pkg::*;

	// returns {quotient bit, new remainder}
	function automatic logic [QW:0] div_step(logic [QW-1:0] rem, logic bit_in, logic [NW-1:0] d);
		logic [QW:0] t;
		logic [QW:0] r;
		t = {rem, bit_in};
		if (32'(t) >= 32'(d)) begin
			r = {1'b1, QW'(32'(t) - 32'(d))};
		end else begin
			r = {1'b0, t[QW-1:0]};
		end
		return r;
	endfunction

	logic [QW-1:0] rem_a_in [QW];
	logic [QW-1:0] low_a_in [QW];
	logic [QW-1:0] quo_a_in [QW];
	logic [QW-1:0] rem_b_in [QW];
	logic [QW-1:0] low_b_in [QW];
	logic [QW-1:0] quo_b_in [QW];
	logic          valid_in [QW];
	ctl_t          ctl_in   [QW];

	logic [QW-1:0] rem_a_s [QW];
	logic [QW-1:0] low_a_s [QW];
	logic [QW-1:0] quo_a_s [QW];
	logic [QW-1:0] rem_b_s [QW];
	logic [QW-1:0] low_b_s [QW];
	logic [QW-1:0] quo_b_s [QW];
	logic          valid_s [QW];
	ctl_t          ctl_s   [QW];

	// a valid site is below divisor squared, so its upper bits are already below the divisor
	assign rem_a_in[0] = QW'(dividend_a >> QW);
	assign low_a_in[0] = dividend_a[QW-1:0];
	assign quo_a_in[0] = '0;
	assign rem_b_in[0] = QW'(dividend_b >> QW);
	assign low_b_in[0] = dividend_b[QW-1:0];
	assign quo_b_in[0] = '0;
	assign valid_in[0] = in_valid;
	assign ctl_in[0]   = in_ctl;

	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic [QW:0] step_a;
		logic [QW:0] step_b;

		if (j > 0) begin : g_link
			assign rem_a_in[j] = rem_a_s[j-1];
			assign low_a_in[j] = low_a_s[j-1];
			assign quo_a_in[j] = quo_a_s[j-1];
			assign rem_b_in[j] = rem_b_s[j-1];
			assign low_b_in[j] = low_b_s[j-1];
			assign quo_b_in[j] = quo_b_s[j-1];
			assign valid_in[j] = valid_s[j-1];
			assign ctl_in[j]   = ctl_s[j-1];
		end

		assign step_a = div_step(rem_a_in[j], low_a_in[j][QW-1], divisor);
		assign step_b = div_step(rem_b_in[j], low_b_in[j][QW-1], divisor);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (en) begin
				valid_s[j] <= valid_in[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_a_s[j] <= step_a[QW-1:0];
				quo_a_s[j] <= QW'({quo_a_in[j], step_a[QW]});
				low_a_s[j] <= QW'({low_a_in[j], 1'b0});
				rem_b_s[j] <= step_b[QW-1:0];
				quo_b_s[j] <= QW'({quo_b_in[j], step_b[QW]});
				low_b_s[j] <= QW'({low_b_in[j], 1'b0});
				ctl_s[j]   <= ctl_in[j];
			end
		end
	end

	assign out_valid = valid_s[QW-1];
	assign out_ctl   = ctl_s[QW-1];
	assign quo_a     = quo_a_s[QW-1];
	assign rem_a     = rem_a_s[QW-1];
	assign quo_b     = quo_b_s[QW-1];
	assign rem_b     = rem_b_s[QW-1];

endmodule

// ===== hdl/tlni_back.sv =====
// tlni_back: split sites into coordinates, wrap the shell offsets, pack or compare, register result
// depends on tlni_pkg and tlni_div
module tlni_back #(
	parameter int MAX_SIDE = tlni_pkg::MAX_SIDE_DEF,
	localparam int NW = $clog2(MAX_SIDE + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [NW-1:0]    n_eff,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  tlni_pkg::entry_t pop_entry,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output tlni_pkg::rsp_t   rsp
);
	import tlni_pkg::*;

	localparam int QW = $clog2(MAX_SIDE);

	function automatic logic [QW-1:0] wrap(logic [QW-1:0] c, logic [2:0] d, logic [NW-1:0] n);
		int v;
		v = int'(c) + int'(d) - 2;
		if (v < 0) begin
			v = v + int'(n);
		end else if (v >= int'(n)) begin
			v = v - int'(n);
		end
		return QW'(v);
	endfunction

	logic          adv;
	logic          d_valid;
	ctl_t          d_ctl;
	logic [QW-1:0] x;
	logic [QW-1:0] y;
	logic [QW-1:0] ox;
	logic [QW-1:0] oy;
	logic [QW-1:0] nx [NB_MAX];
	logic [QW-1:0] ny [NB_MAX];
	logic          hit;

	logic          c_valid_s1;
	ctl_t          c_ctl_s1;
	logic [QW-1:0] c_nx_s1;
	logic [QW-1:0] c_ny_s1;
	logic          c_adj_s1;

	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic [QW+NW-1:0]  prod;
	logic [QW+NW:0]    packed_site;
	logic              emit_site;

	// the whole back pipeline moves only when the result register can take a new item
	assign adv       = !rsp_valid_q || rsp_ready;
	assign pop_ready = adv;

	tlni_div #(.MAX_SIDE(MAX_SIDE)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.in_valid   (pop_valid),
		.in_ctl     (pop_entry.ctl),
		.dividend_a (pop_entry.site),
		.dividend_b (pop_entry.other_site),
		.divisor    (n_eff),
		.out_valid  (d_valid),
		.out_ctl    (d_ctl),
		.quo_a      (y),
		.rem_a      (x),
		.quo_b      (oy),
		.rem_b      (ox)
	);

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < NB_MAX; i++) begin
			nx[i] = wrap(x, SHELL_DX[d_ctl.shell][i], n_eff);
			ny[i] = wrap(y, SHELL_DY[d_ctl.shell][i], n_eff);
			// the sqrt5 shell has all eight neighbors, the others four
			if ((i < 4 || d_ctl.shell == SHELL_SQRT5) && nx[i] == ox && ny[i] == oy) begin
				hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_valid_s1 <= 1'b0;
		end else if (adv) begin
			c_valid_s1 <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_ctl_s1 <= d_ctl;
			c_nx_s1  <= nx[d_ctl.neighbor_number];
			c_ny_s1  <= ny[d_ctl.neighbor_number];
			c_adj_s1 <= hit && (d_ctl.func == FUNC_TEST) && (d_ctl.status == ST_OK);
		end
	end

	assign prod        = {{NW{1'b0}}, c_ny_s1} * {{QW{1'b0}}, n_eff};
	assign packed_site = {1'b0, prod} + (QW+NW+1)'(c_nx_s1);
	assign emit_site   = (c_ctl_s1.status == ST_OK) && (c_ctl_s1.func == FUNC_NEIGHBOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= c_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.neighbor_site <= emit_site ? SITE_W'(packed_site) : '0;
			rsp_q.is_adjacent   <= c_adj_s1;
			rsp_q.status        <= c_ctl_s1.status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hdl/torus_lattice_neighbor_index_unit.sv =====
// torus_lattice_neighbor_index_unit: top level of the periodic lattice neighbor index block
// depends on tlni_pkg, tlni_front, tlni_fifo, tlni_div and tlni_back
//
// usage
// - req channel (valid/ready) takes one query: func, shell, neighbor_number, site, other_site
// - rsp channel (valid/ready) returns one item per query, in order: neighbor_site,
//   is_adjacent, status
// - APB port holds side_length at address 0; pready is always high, reads return the value
//   as written, the side used is clamped to 2..MAX_SIDE
// - site and other_site pass the queue, the divider that splits them into row and column one
//   bit a stage, a stage that picks or compares the neighbor, and the result register
// - throughput is one item per cycle while rsp_ready stays high
// - while rsp_valid is high and rsp_ready low the back pipeline holds; a queue of QUEUE_DEPTH
//   items in front keeps req_ready high until it fills
// - reset empties queue and pipeline and sets side_length to 16; no clearing pass is needed
// - write side_length only while no query is in flight
module torus_lattice_neighbor_index_unit #(
	parameter int MAX_SIDE    = tlni_pkg::MAX_SIDE_DEF,
	parameter int QUEUE_DEPTH = tlni_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tlni_pkg::ADDR_W-1:0] paddr,
	input  logic [tlni_pkg::DATA_W-1:0] pwdata,
	output logic [tlni_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  tlni_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output tlni_pkg::rsp_t              rsp
);
	import tlni_pkg::*;

	localparam int NW = $clog2(MAX_SIDE + 1);
	localparam int TW = 2 * NW;

	logic          push_valid;
	logic          push_ready;
	entry_t        push_entry;
	logic          pop_valid;
	logic          pop_ready;
	entry_t        pop_entry;
	logic [NW-1:0] n_eff;
	logic [TW-1:0] total;

	tlni_front #(.MAX_SIDE(MAX_SIDE)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.n_eff      (n_eff),
		.total      (total)
	);

	tlni_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	tlni_back #(.MAX_SIDE(MAX_SIDE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.n_eff     (n_eff),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// an error result carries no site and no adjacency
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.neighbor_site == '0 && !rsp.is_adjacent)
		else $error("error result carries payload");

	a_adj_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_adjacent |-> rsp.status == ST_OK)
		else $error("adjacency reported with error status");

	// an in-range side write is used as written from the next cycle
	a_side_used: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[2:2] == REG_SIDE_LENGTH
		&& 32'(pwdata[SIDE_W-1:0]) >= 32'd2 && 32'(pwdata[SIDE_W-1:0]) <= 32'(MAX_SIDE)
		|=> 32'(n_eff) == 32'($past(pwdata[SIDE_W-1:0])) && 32'(total) == 32'(n_eff) * 32'(n_eff))
		else $error("side length not taken");

	// the queue only fills through accepted items
	a_fill_by_push: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(req_ready) |-> $past(req_valid))
		else $error("queue full without a push");

endmodule

// ===== dv/torus_lattice_neighbor_index_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench for torus_lattice_neighbor_index_unit: directed and random neighbor queries
// checked item by item against a predictor of the periodic lattice; uses tlni_pkg and the rtl
import tlni_pkg::*;

localparam logic [1:0] SHELL_NEAREST = 2'd0;
localparam logic [1:0] SHELL_DIAG    = 2'd1;
localparam logic [1:0] SHELL_SECOND  = 2'd2;
localparam int LATTICE_MAX  = MAX_SIDE_DEF;
localparam int REPORT_LINES = 40;

class lattice_scoreboard;
	typedef struct packed {
		req_t query;
		rsp_t reply;
	} due_t;

	due_t              due_replies[$];
	logic [SIDE_W-1:0] side_reg;
	int                errors;

	function new();
		side_reg = SIDE_W'(RST_SIDE);
		errors = 0;
	endfunction

	function void set_side(logic [SIDE_W-1:0] value);
		side_reg = value;
	endfunction

	function int side_n();
		int n;
		n = int'(side_reg);
		if (n < 2) begin
			n = 2;
		end else if (n > LATTICE_MAX) begin
			n = LATTICE_MAX;
		end
		return n;
	endfunction

	function int total_sites();
		return side_n() * side_n();
	endfunction

	function int shell_size(logic [1:0] sh);
		return (sh == SHELL_SQRT5) ? NB_MAX : NB_MAX / 2;
	endfunction

	function void shell_offset(input logic [1:0] sh, input int k, output int dx, output int dy);
		int xs[8];
		int ys[8];
		case (sh)
			SHELL_NEAREST: begin
				xs = '{1, 0, -1, 0, 0, 0, 0, 0};
				ys = '{0, 1, 0, -1, 0, 0, 0, 0};
			end
			SHELL_DIAG: begin
				xs = '{1, -1, -1, 1, 0, 0, 0, 0};
				ys = '{1, 1, -1, -1, 0, 0, 0, 0};
			end
			SHELL_SECOND: begin
				xs = '{2, 0, -2, 0, 0, 0, 0, 0};
				ys = '{0, 2, 0, -2, 0, 0, 0, 0};
			end
			default: begin
				xs = '{2, 1, -1, -2, -2, -1, 1, 2};
				ys = '{1, 2, 2, 1, -1, -2, -2, -1};
			end
		endcase
		dx = xs[k];
		dy = ys[k];
	endfunction

	// wrap both coordinates mod n and pack back to row * n + column
	function logic [SITE_W-1:0] neighbor_at(int s, logic [1:0] sh, int k);
		int n;
		int x;
		int y;
		int dx;
		int dy;
		n = side_n();
		x = s % n;
		y = s / n;
		shell_offset(sh, k, dx, dy);
		return SITE_W'(((y + dy + 2 * n) % n) * n + (x + dx + 2 * n) % n);
	endfunction

	function rsp_t lattice_reply(req_t q);
		rsp_t r;
		int   total;
		r = '0;
		total = total_sites();
		// an out-of-range site wins over a bad neighbor number
		if (int'(q.site) >= total || (q.func == FUNC_TEST && int'(q.other_site) >= total)) begin
			r.status = ST_BAD_SITE;
		end else if (q.func == FUNC_NEIGHBOR) begin
			if (int'(q.neighbor_number) >= shell_size(q.shell)) begin
				r.status = ST_BAD_NEIGHBOR;
			end else begin
				r.neighbor_site = neighbor_at(int'(q.site), q.shell, int'(q.neighbor_number));
			end
		end else begin
			for (int i = 0; i < shell_size(q.shell); i++) begin
				if (neighbor_at(int'(q.site), q.shell, i) == q.other_site) begin
					r.is_adjacent = 1'b1;
				end
			end
		end
		return r;
	endfunction

	function void note_query(req_t q);
		due_t d;
		d.query = q;
		d.reply = lattice_reply(q);
		due_replies.push_back(d);
	endfunction

	function int pending();
		return due_replies.size();
	endfunction

	function string describe(req_t q);
		return $sformatf("func %0d shell %0d nb %0d site %0d other %0d side %0d", q.func,
			q.shell, q.neighbor_number, q.site, q.other_site, side_reg);
	endfunction

	task report(string what);
		errors++;
		if (errors <= REPORT_LINES) begin
			$display("%0t mismatch: %s", $time, what);
		end
	endtask

	task check_response(rsp_t got);
		due_t d;
		if (due_replies.size() == 0) begin
			report($sformatf("item with nothing pending: nb %0d adj %0d status %0d",
				got.neighbor_site, got.is_adjacent, got.status));
			return;
		end
		d = due_replies.pop_front();
		if (got.neighbor_site !== d.reply.neighbor_site) begin
			report($sformatf("neighbor_site %0d, want %0d (%s)", got.neighbor_site,
				d.reply.neighbor_site, describe(d.query)));
		end
		if (got.is_adjacent !== d.reply.is_adjacent) begin
			report($sformatf("is_adjacent %0d, want %0d (%s)", got.is_adjacent,
				d.reply.is_adjacent, describe(d.query)));
		end
		if (got.status !== d.reply.status) begin
			report($sformatf("status %0d, want %0d (%s)", got.status, d.reply.status,
				describe(d.query)));
		end
	endtask
endclass

module torus_lattice_neighbor_index_unit_tb;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 400;
	localparam int DRAIN_CYCLES   = 2 * ($clog2(LATTICE_MAX) + 2);
	localparam int PHASE_ITEMS    = 95;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              req_valid;
	logic              req_ready;
	req_t              req;
	logic              rsp_valid;
	logic              rsp_ready;
	rsp_t              rsp;
	bit                pressure_due;
	lattice_scoreboard sb;

	always #5 clk = ~clk;

	torus_lattice_neighbor_index_unit #(
		.MAX_SIDE(LATTICE_MAX)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	function automatic int pick_gap();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 40) return 0;
		if (r < 85) return int'($urandom_range(1, 3));
		if (r < 97) return int'($urandom_range(4, 12));
		return int'($urandom_range(20, 60));
	endfunction

	function automatic int pick_run();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 70) return int'($urandom_range(1, 8));
		if (r < 90) return int'($urandom_range(9, 30));
		return int'($urandom_range(50, 200));
	endfunction

	// mostly well-formed queries on the lattice; some bad sites and neighbor numbers
	function automatic req_t random_query();
		req_t q;
		int   total;
		int   span;
		int   pick;
		total = sb.total_sites();
		q.func = 1'($urandom_range(0, 1));
		q.shell = 2'($urandom_range(0, 3));
		span = sb.shell_size(q.shell);
		if ($urandom_range(0, 6) == 0) begin
			q.neighbor_number = 3'($urandom_range(0, 7));
		end else begin
			q.neighbor_number = 3'($urandom_range(0, span - 1));
		end
		if ($urandom_range(0, 9) == 0) begin
			q.site = SITE_W'($urandom_range(0, 65535));
		end else begin
			q.site = SITE_W'($urandom_range(0, total - 1));
		end
		pick = int'($urandom_range(0, 19));
		if (q.func == FUNC_NEIGHBOR || pick >= 18) begin
			q.other_site = SITE_W'($urandom_range(0, 65535));
		end else if (pick < 9) begin
			q.other_site = sb.neighbor_at(int'(q.site), q.shell, int'($urandom_range(0, span - 1)));
		end else begin
			q.other_site = SITE_W'($urandom_range(0, total - 1));
		end
		return q;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_query(input req_t q, input bit back_to_back);
		int gap;
		req <= q;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sb.note_query(q);
		@(negedge clk);
		gap = back_to_back ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic directed_query(input logic func, input logic [1:0] sh, input int k,
		input int s, input int other);
		req_t q;
		q.func = func;
		q.shell = sh;
		q.neighbor_number = 3'(k);
		q.site = SITE_W'(s);
		q.other_site = SITE_W'(other);
		send_query(q, 1'b0);
	endtask

	task automatic write_side(input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_SIDE_LENGTH, 2'b00};
		pwdata <= DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_side(SIDE_W'(value));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// side 16 from reset
	task automatic run_directed();
		// steps and wrap at the lattice edges
		directed_query(FUNC_NEIGHBOR, SHELL_NEAREST, 0, 0, 0);
		directed_query(FUNC_NEIGHBOR, SHELL_NEAREST, 2, 0, 65535);
		directed_query(FUNC_NEIGHBOR, SHELL_NEAREST, 3, 0, 0);
		directed_query(FUNC_NEIGHBOR, SHELL_DIAG, 0, 255, 0);
		directed_query(FUNC_NEIGHBOR, SHELL_SECOND, 1, 255, 0);
		for (int k = 0; k < NB_MAX; k++) begin
			directed_query(FUNC_NEIGHBOR, SHELL_SQRT5, k, 17, 0);
		end
		// bad neighbor numbers, then a bad site that wins over one
		directed_query(FUNC_NEIGHBOR, SHELL_NEAREST, 4, 5, 0);
		directed_query(FUNC_NEIGHBOR, SHELL_SECOND, 7, 5, 0);
		directed_query(FUNC_NEIGHBOR, SHELL_DIAG, 5, 256, 0);
		directed_query(FUNC_NEIGHBOR, SHELL_SQRT5, 7, 65535, 0);
		// adjacency on the far sqrt5 neighbors; test mode ignores the neighbor number
		directed_query(FUNC_TEST, SHELL_SQRT5, 0, 17, int'(sb.neighbor_at(17, SHELL_SQRT5, 6)));
		directed_query(FUNC_TEST, SHELL_SQRT5, 7, 34, int'(sb.neighbor_at(34, SHELL_SQRT5, 4)));
		directed_query(FUNC_TEST, SHELL_NEAREST, 7, 255,
			int'(sb.neighbor_at(255, SHELL_NEAREST, 0)));
		directed_query(FUNC_TEST, SHELL_DIAG, 0, 100, 100);
		directed_query(FUNC_TEST, SHELL_SECOND, 0, 0, 65535);
		directed_query(FUNC_TEST, SHELL_SECOND, 0, 65535, 0);
	endtask

	task automatic run_random(input int count);
		int burst_left;
		burst_left = 0;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0 && $urandom_range(0, 15) == 0) begin
				burst_left = int'($urandom_range(10, 40));
			end
			send_query(random_query(), burst_left > 0);
			if (burst_left > 0) burst_left--;
		end
	endtask

	// result side: random ready pattern, one long hold-off on request
	initial begin
		int run_left;
		int stall_left;
		bit pressure_taken;
		rsp_ready = 1'b0;
		run_left = 0;
		stall_left = 0;
		pressure_taken = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (pressure_due && !pressure_taken) begin
				pressure_taken = 1'b1;
				run_left = 0;
				stall_left = LONG_HOLD;
			end
			if (run_left == 0 && stall_left == 0) begin
				run_left = pick_run();
				stall_left = pick_gap();
			end
			if (run_left > 0) begin
				rsp_ready <= 1'b1;
				run_left--;
			end else begin
				rsp_ready <= 1'b0;
				stall_left--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_valid && rsp_ready) begin
			sb.check_response(rsp);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("[torus_lattice_neighbor_index_unit] ERROR");
		$finish;
	end

	initial begin
		int side_plan[12];
		side_plan = '{2, 256, 0, 511, 1, 3, 255, 300, 5, 0, 0, 16};
		side_plan[9] = int'($urandom_range(4, 254));
		side_plan[10] = int'($urandom_range(257, 511));
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		req = '0;
		pressure_due = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		foreach (side_plan[p]) begin
			req_valid <= 1'b0;
			wait_drained();
			write_side(side_plan[p]);
			if (side_plan[p] == 2) begin
				// two-site ring: neighbors fold onto each other and onto the site
				directed_query(FUNC_TEST, SHELL_SECOND, 0, 0, 0);
				directed_query(FUNC_NEIGHBOR, SHELL_DIAG, 0, 3, 0);
				directed_query(FUNC_TEST, SHELL_SQRT5, 0, 1, 2);
			end
			// receiver holds off while items keep coming
			if (p == 1) pressure_due = 1'b1;
			run_random(PHASE_ITEMS);
		end
		req_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (sb.errors == 0) begin
			$display("[torus_lattice_neighbor_index_unit] OK");
		end else begin
			$display("[torus_lattice_neighbor_index_unit] ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/tlni_pkg.sv
hdl/tlni_front.sv
hdl/tlni_fifo.sv
hdl/tlni_div.sv
hdl/tlni_back.sv
hdl/torus_lattice_neighbor_index_unit.sv
dv/torus_lattice_neighbor_index_unit_tb.sv
